[src/assert_macros.svh]
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the checker module.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tcop_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tcop_pkg
// Constants, codes and control types shared by the COM-PORT option processor.
// -----------------------------------------------------------------------------
package tcop_pkg;

  localparam int SUBNEG_DEPTH = 24;
  localparam int CNT_W        = $clog2(SUBNEG_DEPTH + 1);
  localparam int ADDR_W       = $clog2(SUBNEG_DEPTH);

  // Telnet bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  // Options
  localparam logic [7:0] OPT_BINARY  = 8'd0;
  localparam logic [7:0] OPT_SGA     = 8'd3;
  localparam logic [7:0] OPT_COMPORT = 8'd44;

  // COM-PORT commands
  localparam logic [7:0] CMD_SET_BAUD     = 8'd1;
  localparam logic [7:0] CMD_SET_DATASIZE = 8'd2;
  localparam logic [7:0] CMD_SET_PARITY   = 8'd3;
  localparam logic [7:0] CMD_SET_STOPSIZE = 8'd4;
  localparam logic [7:0] CMD_LINE_CTRL    = 8'd5;
  localparam logic [7:0] CMD_NOTIFY_MODEM = 8'd7;
  localparam logic [7:0] CMD_ACK_OFFSET   = 8'd100;
  localparam logic [7:0] MODEMSTATE_VAL   = 8'h30;

  // Line control codes
  localparam logic [7:0] CTL_DTR_ON  = 8'd8;
  localparam logic [7:0] CTL_DTR_OFF = 8'd9;
  localparam logic [7:0] CTL_RTS_ON  = 8'd11;
  localparam logic [7:0] CTL_RTS_OFF = 8'd12;

  // Line settings
  localparam logic [31:0] BAUD_MIN   = 32'd300;
  localparam logic [31:0] BAUD_MAX   = 32'd1500000;
  localparam logic [20:0] BAUD_RESET = 21'd115200;

  // Ack length accounting: header bytes, and the payload cutoff
  localparam logic [4:0] ACK_HDR_LEN  = 5'd4;
  localparam logic [4:0] ACK_PL_LIMIT = 5'd21;

  typedef enum logic [2:0] {
    PS_DATA, PS_IAC, PS_VERB, PS_SB, PS_SB_IAC
  } parse_state_t;

  typedef enum logic [3:0] {
    SEL_DATA, SEL_IAC, SEL_VERB, SEL_OPT, SEL_SB, SEL_COMPORT, SEL_CMD, SEL_PL, SEL_SE
  } sel_t;

  typedef enum logic [2:0] {
    PK_BAUD, PK_DSZ, PK_PAR, PK_STOP, PK_CTRL, PK_NOTIFY, PK_MEM
  } pl_kind_t;

  typedef enum logic [3:0] {
    CS_IDLE, CS_DISPATCH, CS_VERB_IAC, CS_VERB_CODE, CS_VERB_OPT, CS_SUB,
    CS_HDR_IAC, CS_HDR_SB, CS_HDR_OPT, CS_HDR_CMD, CS_FETCH, CS_PL,
    CS_END_IAC, CS_END_SE
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic setup_notify;
    logic sub_eval;
    logic fetch;
    logic emit;
    sel_t sel;
    logic last;
    logic pl_esc;
    logic pl_adv;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic f_data;
    logic f_verb;
    logic f_notify;
    logic f_sub;
    logic sub_ack;
    logic has_pl;
    logic pl_esc;
    logic pl_more;
  } dp_status_t;

endpackage

[src/tcop_datapath.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tcop_datapath
// Parser registers, subnegotiation store, line settings and output word register.
// -----------------------------------------------------------------------------
module tcop_datapath import tcop_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic [7:0]  in_byte,
  input  logic        in_action,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_dest,
  output logic        out_last,
  output logic [20:0] out_baud,
  output logic [3:0]  out_databits,
  output logic [1:0]  out_parity,
  output logic [1:0]  out_stop,
  output logic        out_dtr,
  output logic        out_rts
);

  logic             telnet_en;
  parse_state_t     pstate;
  logic [7:0]       held_verb;
  logic [CNT_W-1:0] count;
  logic             comport_on;
  logic [20:0]      baud;
  logic [3:0]       databits;
  logic [1:0]       parity;
  logic [1:0]       stop;
  logic             dtr;
  logic             rts;

  logic f_data, f_verb, f_notify, f_sub;
  logic f_data_next, f_verb_next, f_notify_next, f_sub_next;
  logic [7:0] data_byte, verb_reply, opt_reply;

  logic [7:0]       ack_cmd;
  pl_kind_t         ack_kind;
  logic [CNT_W-1:0] ack_n;
  logic [CNT_W-1:0] pl_idx;
  logic [4:0]       ack_w;
  logic             esc_done;
  logic [7:0]       pl_byte;

  logic [7:0] mem [SUBNEG_DEPTH];
  logic [7:0] opt_byte, cmd_byte;
  logic [7:0] pl_head [4];

  logic             opt_ok;
  logic             room;
  logic             mem_we;
  logic [CNT_W-1:0] pln;
  logic [31:0]      want;
  logic [7:0]       emit_byte;
  logic [ADDR_W-1:0] rd_addr;

  assign opt_ok = (in_byte == OPT_BINARY) || (in_byte == OPT_SGA) ||
                  (in_byte == OPT_COMPORT);
  assign room   = count < CNT_W'(SUBNEG_DEPTH);
  assign mem_we = cmd.accept && !in_action && telnet_en && room &&
                  (((pstate == PS_SB) && (in_byte != B_IAC)) ||
                   ((pstate == PS_SB_IAC) && (in_byte == B_IAC)));
  assign pln    = count - CNT_W'(2);
  assign want   = {pl_head[0], pl_head[1], pl_head[2], pl_head[3]};
  assign rd_addr = ADDR_W'(pl_idx + CNT_W'(2));

  assign status.out_free = !out_valid || out_ready;
  assign status.f_data   = f_data;
  assign status.f_verb   = f_verb;
  assign status.f_notify = f_notify;
  assign status.f_sub    = f_sub;
  assign status.sub_ack  = (count >= CNT_W'(2)) && (opt_byte == OPT_COMPORT) &&
                           ((cmd_byte != CMD_LINE_CTRL) || (count >= CNT_W'(3)));
  assign status.has_pl   = ack_n != '0;
  assign status.pl_esc   = (pl_byte == B_IAC) && !esc_done;
  assign status.pl_more  = ((pl_idx + CNT_W'(1)) < ack_n) &&
                           ((ack_w + 5'd1) < ACK_PL_LIMIT);

  // Work for the sequencer that the accepted word calls for
  always_comb begin
    f_data_next   = 1'b0;
    f_verb_next   = 1'b0;
    f_notify_next = 1'b0;
    f_sub_next    = 1'b0;
    if (!in_action) begin
      if (!telnet_en) begin
        f_data_next = 1'b1;
      end else begin
        case (pstate)
          PS_IAC:    f_data_next = (in_byte == B_IAC);
          PS_VERB: begin
            f_verb_next   = (held_verb == B_WILL) || (held_verb == B_DO);
            f_notify_next = opt_ok && (in_byte == OPT_COMPORT) && !comport_on;
          end
          PS_SB:     f_sub_next = 1'b0;
          PS_SB_IAC: f_sub_next = (in_byte != B_IAC);
          default:   f_data_next = (in_byte != B_IAC);
        endcase
      end
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_DATA:    emit_byte = data_byte;
      SEL_IAC:     emit_byte = B_IAC;
      SEL_VERB:    emit_byte = verb_reply;
      SEL_OPT:     emit_byte = opt_reply;
      SEL_SB:      emit_byte = B_SB;
      SEL_COMPORT: emit_byte = OPT_COMPORT;
      SEL_CMD:     emit_byte = ack_cmd;
      SEL_PL:      emit_byte = pl_byte;
      SEL_SE:      emit_byte = B_SE;
      default:     emit_byte = data_byte;
    endcase
  end

  // Control state, settings and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      telnet_en  <= 1'b0;
      pstate     <= PS_DATA;
      held_verb  <= '0;
      count      <= '0;
      comport_on <= 1'b0;
      baud       <= BAUD_RESET;
      databits   <= 4'd8;
      parity     <= 2'd0;
      stop       <= 2'd1;
      dtr        <= 1'b1;
      rts        <= 1'b1;
      f_data     <= 1'b0;
      f_verb     <= 1'b0;
      f_notify   <= 1'b0;
      f_sub      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        telnet_en <= cfg_wr_data;
      end
      if (cmd.accept) begin
        f_data   <= f_data_next;
        f_verb   <= f_verb_next;
        f_notify <= f_notify_next;
        f_sub    <= f_sub_next;
        if (in_action) begin
          pstate     <= PS_DATA;
          held_verb  <= '0;
          count      <= '0;
          comport_on <= 1'b0;
          dtr        <= 1'b1;
          rts        <= 1'b1;
        end else if (telnet_en) begin
          case (pstate)
            PS_IAC: begin
              if (in_byte == B_IAC) begin
                pstate <= PS_DATA;
              end else if (in_byte == B_SB) begin
                pstate <= PS_SB;
                count  <= '0;
              end else if (in_byte inside {[B_WILL:B_DONT]}) begin
                held_verb <= in_byte;
                pstate    <= PS_VERB;
              end else begin
                pstate <= PS_DATA;
              end
            end
            PS_VERB: begin
              if (f_notify_next) begin
                comport_on <= 1'b1;
              end
              pstate <= PS_DATA;
            end
            PS_SB: begin
              if (in_byte == B_IAC) begin
                pstate <= PS_SB_IAC;
              end else if (room) begin
                count <= count + CNT_W'(1);
              end
            end
            PS_SB_IAC: begin
              if (in_byte == B_IAC) begin
                if (room) begin
                  count <= count + CNT_W'(1);
                end
                pstate <= PS_SB;
              end else begin
                pstate <= PS_DATA;
              end
            end
            default: begin
              // Data state; unused codes fall here too
              if (in_byte == B_IAC) begin
                pstate <= PS_IAC;
              end else begin
                pstate <= PS_DATA;
              end
            end
          endcase
        end
      end
      if (cmd.sub_eval && status.sub_ack) begin
        case (cmd_byte)
          CMD_SET_BAUD: begin
            if ((pln >= CNT_W'(4)) && (want >= BAUD_MIN) && (want <= BAUD_MAX)) begin
              baud <= want[20:0];
            end
          end
          CMD_SET_DATASIZE: begin
            if ((pln >= CNT_W'(1)) && (pl_head[0] inside {[8'd5:8'd8]})) begin
              databits <= pl_head[0][3:0];
            end
          end
          CMD_SET_PARITY: begin
            if ((pln >= CNT_W'(1)) && (pl_head[0] inside {[8'd1:8'd3]})) begin
              parity <= 2'(pl_head[0] - 8'd1);
            end
          end
          CMD_SET_STOPSIZE: begin
            if ((pln >= CNT_W'(1)) && (pl_head[0] inside {8'd1, 8'd2})) begin
              stop <= pl_head[0][1:0];
            end
          end
          CMD_LINE_CTRL: begin
            case (pl_head[0])
              CTL_DTR_ON:  dtr <= 1'b0;
              CTL_DTR_OFF: dtr <= 1'b1;
              CTL_RTS_ON:  rts <= 1'b0;
              CTL_RTS_OFF: rts <= 1'b1;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: held bytes, ack bookkeeping, store and output word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_byte <= in_byte;
      opt_reply <= in_byte;
      if (held_verb == B_WILL) begin
        verb_reply <= opt_ok ? B_DO : B_DONT;
      end else begin
        verb_reply <= opt_ok ? B_WILL : B_WONT;
      end
    end
    if (mem_we) begin
      mem[count[ADDR_W-1:0]] <= in_byte;
      if (count == CNT_W'(0)) begin
        opt_byte <= in_byte;
      end
      if (count == CNT_W'(1)) begin
        cmd_byte <= in_byte;
      end
      if ((count >= CNT_W'(2)) && (count < CNT_W'(6))) begin
        pl_head[2'(count - CNT_W'(2))] <= in_byte;
      end
    end
    if (cmd.setup_notify) begin
      ack_cmd  <= CMD_NOTIFY_MODEM + CMD_ACK_OFFSET;
      ack_kind <= PK_NOTIFY;
      ack_n    <= CNT_W'(1);
      pl_idx   <= '0;
      ack_w    <= ACK_HDR_LEN;
      esc_done <= 1'b0;
    end
    if (cmd.sub_eval) begin
      ack_cmd  <= cmd_byte + CMD_ACK_OFFSET;
      pl_idx   <= '0;
      ack_w    <= ACK_HDR_LEN;
      esc_done <= 1'b0;
      case (cmd_byte)
        CMD_SET_BAUD: begin
          ack_kind <= PK_BAUD;
          ack_n    <= CNT_W'(4);
        end
        CMD_SET_DATASIZE: begin
          ack_kind <= PK_DSZ;
          ack_n    <= CNT_W'(1);
        end
        CMD_SET_PARITY: begin
          ack_kind <= PK_PAR;
          ack_n    <= CNT_W'(1);
        end
        CMD_SET_STOPSIZE: begin
          ack_kind <= PK_STOP;
          ack_n    <= CNT_W'(1);
        end
        CMD_LINE_CTRL: begin
          ack_kind <= PK_CTRL;
          ack_n    <= CNT_W'(1);
        end
        default: begin
          ack_kind <= PK_MEM;
          ack_n    <= pln;
        end
      endcase
    end
    if (cmd.fetch) begin
      case (ack_kind)
        PK_BAUD: begin
          case (pl_idx[1:0])
            2'd0:    pl_byte <= 8'd0;
            2'd1:    pl_byte <= {3'b000, baud[20:16]};
            2'd2:    pl_byte <= baud[15:8];
            default: pl_byte <= baud[7:0];
          endcase
        end
        PK_DSZ:    pl_byte <= {4'b0000, databits};
        PK_PAR:    pl_byte <= {6'b000000, parity} + 8'd1;
        PK_STOP:   pl_byte <= {6'b000000, stop};
        PK_CTRL:   pl_byte <= pl_head[0];
        PK_NOTIFY: pl_byte <= MODEMSTATE_VAL;
        default:   pl_byte <= mem[rd_addr];
      endcase
    end
    if (cmd.pl_esc) begin
      ack_w    <= ack_w + 5'd1;
      esc_done <= 1'b1;
    end
    if (cmd.pl_adv) begin
      ack_w    <= ack_w + 5'd1;
      pl_idx   <= pl_idx + CNT_W'(1);
      esc_done <= 1'b0;
    end
    if (cmd.emit) begin
      out_byte     <= emit_byte;
      out_dest     <= cmd.sel != SEL_DATA;
      out_last     <= cmd.last;
      out_baud     <= baud;
      out_databits <= databits;
      out_parity   <= parity;
      out_stop     <= stop;
      out_dtr      <= dtr;
      out_rts      <= rts;
    end
  end

endmodule

[src/tcop_controller.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tcop_controller
// Sequences each accepted word through replies, acks and output emission.
// -----------------------------------------------------------------------------
module tcop_controller import tcop_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = SEL_DATA;
    in_ready   = 1'b0;
    case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = CS_DISPATCH;
        end
      end
      CS_DISPATCH: begin
        if (status.f_data) begin
          if (status.out_free) begin
            cmd.emit   = 1'b1;
            cmd.sel    = SEL_DATA;
            cmd.last   = 1'b1;
            state_next = CS_IDLE;
          end
        end else if (status.f_verb) begin
          state_next = CS_VERB_IAC;
        end else if (status.f_notify) begin
          cmd.setup_notify = 1'b1;
          state_next       = CS_HDR_IAC;
        end else if (status.f_sub) begin
          state_next = CS_SUB;
        end else begin
          state_next = CS_IDLE;
        end
      end
      CS_VERB_IAC: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_IAC;
          state_next = CS_VERB_CODE;
        end
      end
      CS_VERB_CODE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_VERB;
          state_next = CS_VERB_OPT;
        end
      end
      CS_VERB_OPT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_OPT;
          cmd.last = !status.f_notify;
          if (status.f_notify) begin
            cmd.setup_notify = 1'b1;
            state_next       = CS_HDR_IAC;
          end else begin
            state_next = CS_IDLE;
          end
        end
      end
      CS_SUB: begin
        cmd.sub_eval = 1'b1;
        state_next   = status.sub_ack ? CS_HDR_IAC : CS_IDLE;
      end
      CS_HDR_IAC: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_IAC;
          state_next = CS_HDR_SB;
        end
      end
      CS_HDR_SB: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_SB;
          state_next = CS_HDR_OPT;
        end
      end
      CS_HDR_OPT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_COMPORT;
          state_next = CS_HDR_CMD;
        end
      end
      CS_HDR_CMD: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_CMD;
          state_next = status.has_pl ? CS_FETCH : CS_END_IAC;
        end
      end
      CS_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = CS_PL;
      end
      CS_PL: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.pl_esc) begin
            cmd.sel    = SEL_IAC;
            cmd.pl_esc = 1'b1;
          end else begin
            cmd.sel    = SEL_PL;
            cmd.pl_adv = 1'b1;
            state_next = status.pl_more ? CS_FETCH : CS_END_IAC;
          end
        end
      end
      CS_END_IAC: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_IAC;
          state_next = CS_END_SE;
        end
      end
      CS_END_SE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_SE;
          cmd.last   = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

[src/telnet_comport_option_processor.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// telnet_comport_option_processor
// Telnet receive parser with COM-PORT option handling and line settings.
// -----------------------------------------------------------------------------
//
//  Channel   Dir  Carries
//  s_axis    in   received byte (tdata) and session reset flag (tuser)
//  m_axis    out  line data or reply byte, dest (tuser), end of replies (tlast)
//  cfg       in   telnet_enable write, single register
//
// Order: one word in at a time. A plain data byte is accepted, then emitted.
// A verb reply emits IAC, verb and option; a subnegotiation ack emits its header,
// each payload byte after its fetch (an IAC payload byte escaped), then IAC SE;
// the sequencer emits at most one reply byte per cycle while the output is free.
// Reset: rst is synchronous; settings go to 115200 8N1 with DTR/RTS released.
// Stalls: a held output word halts the sequencer; input waits until all
// replies of the current word have been produced.
//
module telnet_comport_option_processor import tcop_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,     // telnet_enable
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
  input  logic        s_axis_tuser,    // [0] action (1 = session reset)
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,    // [7:0] out_byte, [28:8] line_baud,
                                       // [32:29] char_size, [34:33] parity_mode,
                                       // [36:35] stop_count, [37] dtr_level,
                                       // [38] rts_level, [39] zero
  output logic        m_axis_tuser,    // [0] dest (1 = reply to client)
  output logic        m_axis_tlast     // last word caused by this input
);

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [7:0]  out_byte;
  logic [20:0] out_baud;
  logic [3:0]  out_databits;
  logic [1:0]  out_parity;
  logic [1:0]  out_stop;
  logic        out_dtr;
  logic        out_rts;

  // Sequencer: owns the handshake on the input side and the reply order
  tcop_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Parser state, store, settings and the output word register
  tcop_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_byte      (s_axis_tdata),
    .in_action    (s_axis_tuser),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_byte     (out_byte),
    .out_dest     (m_axis_tuser),
    .out_last     (m_axis_tlast),
    .out_baud     (out_baud),
    .out_databits (out_databits),
    .out_parity   (out_parity),
    .out_stop     (out_stop),
    .out_dtr      (out_dtr),
    .out_rts      (out_rts)
  );

  // Pack settings snapshot beside the byte, low field first
  assign m_axis_tdata = {1'b0, out_rts, out_dtr, out_stop, out_parity,
                         out_databits, out_baud, out_byte};

endmodule

[src/tcop_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tcop_checker
// Port-level checks on the option processor, bound to the top level.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcop_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // Hold a stalled output word
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed under stall")

  // Line data words always close their input
  `ASSERT_SAME(a_data_last, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tlast, "data word without tlast")

  // One word in flight: input closes right after an accept
  `ASSERT_NEXT(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted back to back")

  // Settings stay in their legal ranges
  `ASSERT_SAME(a_settings, clk, rst, m_axis_tvalid, (m_axis_tdata[36:35] == 2'd1 || m_axis_tdata[36:35] == 2'd2) && m_axis_tdata[34:33] != 2'd3, "settings out of range")

endmodule

bind telnet_comport_option_processor tcop_checker u_chk (.*);

[tb/telnet_comport_option_processor_test.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// telnet_comport_option_processor_test
// Streams bytes and session resets into the COM-PORT option processor in raw
// and telnet mode, predicts every output word from an internal copy of the
// parser and line settings, and compares whole words, tuser and tlast included.
// -----------------------------------------------------------------------------
module telnet_comport_option_processor_test;
  import tcop_pkg::*;

  // one output word as the predictor sees it
  typedef struct {
    logic [7:0]  ob;
    logic        dst;
    logic        lst;
    logic [20:0] baud;
    logic [3:0]  dbits;
    logic [1:0]  par;
    logic [1:0]  stp;
    logic        dtr;
    logic        rts;
  } word_t;

  localparam int LIMIT_CYCLES = 600000;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  telnet_comport_option_processor uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // pending input words: {session_reset, byte}
  logic [8:0] pending_words[$];
  word_t      expected_words[$];
  int         errors = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_off_cycles = 0;

  // predictor copy of the block
  bit          tn_mode;
  parse_state_t ps;
  logic [7:0]  verb_hold;
  logic [7:0]  sub_mem[SUBNEG_DEPTH];
  int          sub_cnt;
  bit          cp_live;
  logic [20:0] p_baud;
  logic [3:0]  p_dbits;
  logic [1:0]  p_par;
  logic [1:0]  p_stp;
  logic        p_dtr, p_rts;
  logic [7:0]  step_bytes[$];
  logic        step_dest[$];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic void push_reply(logic [7:0] b, logic d);
    if (step_bytes.size() < 24) begin
      step_bytes.push_back(b);
      step_dest.push_back(d);
    end
  endfunction

  // ack: header, escaped payload cut to fit 24 bytes, trailer
  function automatic void push_ack(logic [7:0] cmd, logic [7:0] pl[$]);
    int w;
    w = 4;
    push_reply(B_IAC, 1); push_reply(B_SB, 1); push_reply(OPT_COMPORT, 1);
    push_reply(cmd + CMD_ACK_OFFSET, 1);
    for (int i = 0; i < pl.size() && w < 21; i++) begin
      if (pl[i] == B_IAC) begin
        push_reply(B_IAC, 1);
        w++;
      end
      push_reply(pl[i], 1);
      w++;
    end
    push_reply(B_IAC, 1); push_reply(B_SE, 1);
  endfunction

  function automatic void answer_option(logic [7:0] vb, logic [7:0] opt);
    bit ok;
    logic [7:0] pl[$];
    ok = (opt == OPT_BINARY || opt == OPT_SGA || opt == OPT_COMPORT);
    if (vb == B_WILL) begin
      push_reply(B_IAC, 1); push_reply(ok ? B_DO : B_DONT, 1); push_reply(opt, 1);
    end else if (vb == B_DO) begin
      push_reply(B_IAC, 1); push_reply(ok ? B_WILL : B_WONT, 1); push_reply(opt, 1);
    end
    if (opt == OPT_COMPORT && !cp_live) begin
      cp_live = 1;
      pl.push_back(MODEMSTATE_VAL);
      push_ack(CMD_NOTIFY_MODEM, pl);
    end
  endfunction

  function automatic void finish_subneg();
    logic [7:0] cmd;
    logic [7:0] pl[$];
    logic [7:0] echo[$];
    logic [31:0] want;
    if (sub_cnt < 2 || sub_mem[0] != OPT_COMPORT) return;
    cmd = sub_mem[1];
    for (int i = 2; i < sub_cnt; i++) pl.push_back(sub_mem[i]);
    case (cmd)
      CMD_SET_BAUD: begin
        if (pl.size() >= 4) begin
          want = {pl[0], pl[1], pl[2], pl[3]};
          if (want >= BAUD_MIN && want <= BAUD_MAX) p_baud = want[20:0];
        end
        echo = '{8'd0, {3'd0, p_baud[20:16]}, p_baud[15:8], p_baud[7:0]};
        push_ack(cmd, echo);
      end
      CMD_SET_DATASIZE: begin
        if (pl.size() >= 1 && pl[0] >= 5 && pl[0] <= 8) p_dbits = pl[0][3:0];
        echo.push_back({4'd0, p_dbits});
        push_ack(cmd, echo);
      end
      CMD_SET_PARITY: begin
        if (pl.size() >= 1 && pl[0] >= 1 && pl[0] <= 3) p_par = pl[0][1:0] - 2'd1;
        echo.push_back({6'd0, p_par} + 8'd1);
        push_ack(cmd, echo);
      end
      CMD_SET_STOPSIZE: begin
        if (pl.size() >= 1 && (pl[0] == 1 || pl[0] == 2)) p_stp = pl[0][1:0];
        echo.push_back({6'd0, p_stp});
        push_ack(cmd, echo);
      end
      CMD_LINE_CTRL: begin
        // empty control request gets no ack
        if (pl.size() >= 1) begin
          if (pl[0] == CTL_DTR_ON) p_dtr = 0;
          else if (pl[0] == CTL_DTR_OFF) p_dtr = 1;
          else if (pl[0] == CTL_RTS_ON) p_rts = 0;
          else if (pl[0] == CTL_RTS_OFF) p_rts = 1;
          echo.push_back(pl[0]);
          push_ack(cmd, echo);
        end
      end
      default: push_ack(cmd, pl);
    endcase
  endfunction

  function automatic void store_sub(logic [7:0] b);
    if (sub_cnt < SUBNEG_DEPTH) begin
      sub_mem[sub_cnt] = b;
      sub_cnt++;
    end
  endfunction

  // advance the predictor by one accepted word and queue its results
  function automatic void predict_word(logic [8:0] w);
    logic [7:0] b;
    word_t e;
    b = w[7:0];
    step_bytes.delete(); step_dest.delete();
    if (w[8]) begin
      ps = PS_DATA; verb_hold = 0; sub_cnt = 0; cp_live = 0;
      p_dtr = 1; p_rts = 1;
      return;
    end
    if (!tn_mode) push_reply(b, 0);
    else begin
      case (ps)
        PS_IAC: begin
          if (b == B_IAC) begin
            ps = PS_DATA; push_reply(b, 0);
          end else if (b == B_SB) begin
            ps = PS_SB; sub_cnt = 0;
          end else if (b >= B_WILL && b <= B_DONT) begin
            verb_hold = b; ps = PS_VERB;
          end else ps = PS_DATA;
        end
        PS_VERB: begin
          answer_option(verb_hold, b);
          ps = PS_DATA;
        end
        PS_SB: begin
          if (b == B_IAC) ps = PS_SB_IAC;
          else store_sub(b);
        end
        PS_SB_IAC: begin
          if (b == B_IAC) begin
            store_sub(B_IAC); ps = PS_SB;
          end else begin
            finish_subneg(); ps = PS_DATA;
          end
        end
        default: begin
          if (b == B_IAC) ps = PS_IAC;
          else push_reply(b, 0);
        end
      endcase
    end
    for (int k = 0; k < step_bytes.size(); k++) begin
      e.ob = step_bytes[k]; e.dst = step_dest[k];
      e.lst = (k == step_bytes.size() - 1);
      e.baud = p_baud; e.dbits = p_dbits; e.par = p_par; e.stp = p_stp;
      e.dtr = p_dtr; e.rts = p_rts;
      expected_words.push_back(e);
    end
  endfunction

  // driver: offer pending words, idling at the current rate
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_word({s_axis_tuser, s_axis_tdata});
        void'(pending_words.pop_front());
      end
      if ((!s_axis_tvalid || s_axis_tready) ) begin
        if (pending_words.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
            pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1;
          s_axis_tdata  <= pending_words[0][7:0];
          s_axis_tuser  <= pending_words[0][8];
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // monitor: accept output words with random stalls, compare in order
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h tuser %b tlast %b", $realtime,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end else begin
          word_t e;
          e = expected_words.pop_front();
          if (m_axis_tdata !== {1'b0, e.rts, e.dtr, e.stp, e.par, e.dbits, e.baud, e.ob} ||
              m_axis_tuser !== e.dst || m_axis_tlast !== e.lst) begin
            $display("%0t: expected byte %h dest %b last %b baud %0d bits %0d par %0d stop %0d dtr %b rts %b",
                     $realtime, e.ob, e.dst, e.lst, e.baud, e.dbits, e.par, e.stp, e.dtr, e.rts);
            $display("%0t: actual   tdata %h tuser %b tlast %b", $realtime,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
            errors++;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("telnet_comport_option_processor_test: errors");
      $finish;
    end
  end

  task automatic add_word(bit rst_flag, logic [7:0] b);
    pending_words.push_back({rst_flag, b});
  endtask

  task automatic add_subneg(logic [7:0] bytes[$]);
    add_word(0, B_IAC); add_word(0, B_SB);
    foreach (bytes[i]) begin
      add_word(0, bytes[i]);
      if (bytes[i] == B_IAC) add_word(0, B_IAC);
    end
    add_word(0, B_IAC); add_word(0, B_SE);
  endtask

  // wait until every queued word has gone in and every result has come out
  task automatic drain();
    while (pending_words.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_mode(bit v);
    @(posedge clk);
    cfg_wr_en <= 1; cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    tn_mode = v;
  endtask

  // a random well-formed command sequence with random content
  task automatic add_random_command();
    logic [7:0] sb[$];
    int n, pick;
    pick = $urandom_range(9);
    case (pick)
      0, 1: begin
        add_word(0, B_IAC);
        add_word(0, 8'($urandom_range(B_WILL, B_DONT)));
        add_word(0, $urandom_range(3) == 0 ? 8'($urandom) :
                     ($urandom_range(1) ? OPT_COMPORT : OPT_SGA));
      end
      2: begin
        sb = '{OPT_COMPORT, CMD_SET_BAUD};
        if ($urandom_range(3) == 0) begin
          for (int i = 0; i < 4; i++) sb.push_back(8'($urandom));
        end else begin
          logic [31:0] v;
          v = $urandom_range(1500100, 250);
          sb.push_back(v[31:24]); sb.push_back(v[23:16]);
          sb.push_back(v[15:8]); sb.push_back(v[7:0]);
        end
        add_subneg(sb);
      end
      3, 4: begin
        sb = '{OPT_COMPORT, 8'($urandom_range(CMD_SET_DATASIZE, CMD_LINE_CTRL))};
        sb.push_back($urandom_range(1) ? 8'($urandom_range(13)) : 8'($urandom));
        add_subneg(sb);
      end
      5: begin
        sb = '{$urandom_range(4) == 0 ? 8'($urandom) : OPT_COMPORT, 8'($urandom)};
        n = $urandom_range(3) == 0 ? $urandom_range(30) : $urandom_range(4);
        for (int i = 0; i < n; i++) sb.push_back(8'($urandom));
        add_subneg(sb);
      end
      6: add_word(1, 8'($urandom));
      7: begin
        add_word(0, B_IAC); add_word(0, 8'($urandom));
      end
      default: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) add_word(0, 8'($urandom));
      end
    endcase
  endtask

  initial begin
    logic [7:0] sb[$];
    rst = 1;
    cfg_wr_en = 0; cfg_wr_data = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    m_axis_tready = 0;
    tn_mode = 0; ps = PS_DATA; verb_hold = 0; sub_cnt = 0; cp_live = 0;
    p_baud = BAUD_RESET; p_dbits = 4'd8; p_par = 0; p_stp = 2'd1;
    p_dtr = 1; p_rts = 1;
    repeat (9) @(posedge clk);
    rst <= 0;

    // raw mode: extremes pass unchanged, session reset emits nothing
    add_word(0, 8'h00); add_word(0, 8'hFF); add_word(0, 8'hAA); add_word(1, 8'h55);
    drain();

    write_mode(1);
    // telnet directed: escaped IAC, verbs, notify, commands, special cases
    add_word(0, 8'h41); add_word(0, B_IAC); add_word(0, B_IAC);
    add_word(0, B_IAC); add_word(0, B_WILL); add_word(0, OPT_BINARY);
    add_word(0, B_IAC); add_word(0, B_DO); add_word(0, 8'd99);
    add_word(0, B_IAC); add_word(0, B_WONT); add_word(0, OPT_COMPORT);
    add_word(0, B_IAC); add_word(0, 8'd241);
    add_subneg('{OPT_COMPORT, CMD_SET_BAUD, 8'h00, 8'h16, 8'hE3, 8'h60});
    add_subneg('{OPT_COMPORT, CMD_SET_BAUD, 8'h00, 8'h00, 8'h00, 8'h01});
    add_subneg('{OPT_COMPORT, CMD_SET_DATASIZE, 8'd5});
    add_subneg('{OPT_COMPORT, CMD_SET_PARITY, 8'd3});
    add_subneg('{OPT_COMPORT, CMD_SET_STOPSIZE, 8'd2});
    add_subneg('{OPT_COMPORT, CMD_LINE_CTRL, CTL_DTR_ON});
    add_subneg('{OPT_COMPORT, CMD_LINE_CTRL});
    add_subneg('{OPT_COMPORT});
    sb = '{OPT_COMPORT, 8'd77};
    for (int i = 0; i < 30; i++) sb.push_back(i % 3 == 0 ? B_IAC : 8'(i));
    add_subneg(sb);
    add_word(1, 8'h00);
    add_word(0, B_IAC); add_word(0, B_WILL); add_word(0, OPT_COMPORT);
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 56 : (phase == 3) ? 17 : 0;
      recv_stall_pct = (phase == 2) ? 56 : (phase == 3) ? 17 : 0;
      if (phase == 2) begin
        write_mode(0);
        for (int i = 0; i < 20; i++) add_word($urandom_range(7) == 0, 8'($urandom));
        drain();
        write_mode(1);
      end
      if (phase == 1) begin
        hold_off_cycles = 400;
        // plain data words so the output surely backs up during the hold-off
        for (int i = 0; i < 6; i++) add_word(0, 8'(8'h30 + i));
      end
      for (int i = 0; i < 4; i++) add_random_command();
      drain();
    end
    if (errors == 0) $display("telnet_comport_option_processor_test: clean");
    else $display("telnet_comport_option_processor_test: errors");
    $finish;
  end

endmodule
